@@ src/sha256mh_pkg.sv @@
`default_nettype none

package sha256mh_pkg;

	typedef struct packed {
		logic [31:0] message_word;
		logic        padding_end;
		logic [60:0] message_bytes;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

endpackage

`default_nettype wire

@@ src/sha256_message_hasher_top.sv @@
// SHA-256 hasher for a message padded up to, but not including, the 64-bit length.
// msg channel: one 32-bit big-endian word per request (msg_valid / msg_stall).
//   The request with padding_end set also carries the byte count; the block then
//   adds zero words and the two length words itself.
// dig channel: eight requests per message, digest word 0 (most significant) first,
//   last_word set on the eighth.
// Input flow: a word that does not close a 16-word block is taken at once.
//   A closing word starts a compression: the hash words are loaded from the hash
//   RAM into the round registers, 64 rounds run at one per cycle (schedule words
//   0-15 read from the schedule RAM, the rest expanded in a 16-word window), and
//   the results are added back into the hash RAM; msg_stall is high meanwhile.
// Output: after the padding_end request, the padding and length words enter at one
//   per cycle, and one or two compressions run; each digest word is then read from
//   the hash RAM and registered on dig. A stalled digest word holds until taken.
// Reset: the hash RAM reads as the standard initial values (per-entry valid bits),
//   the word count is cleared, and the block is ready for a new message at once.
//   After the last digest word the initial values are back in place.
`default_nettype none

module sha256_message_hasher_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                msg_valid,
	output      logic                msg_stall,
	input  wire sha256mh_pkg::msg_t  msg,
	output      logic                dig_valid,
	input  wire logic                dig_stall,
	output      sha256mh_pkg::dig_t  dig
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_ORD,
		ST_OLD,
		ST_OWAIT
	} state_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] sml_s0(input logic [31:0] x);
		sml_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sml_s1(input logic [31:0] x);
		sml_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	state_t        state_q;
	logic [5:0]    cnt_q;
	logic [3:0]    pos_q;
	logic          pad_q;
	logic          hi_q;
	logic          fin_q;
	logic [60:0]   len_q;
	logic [7:0]    hvld_q;
	logic [31:0]   v_q [8];
	logic [31:0]   win_q [16];
	logic          dig_valid_q;
	sha256mh_pkg::dig_t dig_q;

	// memories
	logic [31:0]   sched_mem [16];
	logic [31:0]   hash_mem [8];
	logic [31:0]   sched_rd_s1;
	logic [31:0]   hash_rd_s1;
	logic          hash_vld_s1;
	logic [2:0]    hash_raddr_s1;

	logic          sched_we;
	logic [31:0]   sched_wdata;
	logic [3:0]    sched_raddr;
	logic          hash_we;
	logic [2:0]    hash_raddr;
	logic [2:0]    hash_waddr;
	logic [31:0]   hash_wdata;
	logic [31:0]   hash_eff;
	logic [63:0]   bit_len;
	logic [31:0]   w_cur;
	logic [31:0]   t1;
	logic [31:0]   t2;

	assign msg_stall = (state_q != ST_IDLE);
	assign dig_valid = dig_valid_q;
	assign dig       = dig_q;

	assign bit_len    = {len_q, 3'b000};
	assign hash_raddr = cnt_q[2:0];
	assign hash_waddr = cnt_q[2:0] - 3'd1;
	// an entry not yet written since reset or since the last digest holds the IV
	assign hash_eff   = hash_vld_s1 ? hash_rd_s1 : sha256mh_pkg::INIT_HASH[hash_raddr_s1];
	assign hash_we    = (state_q == ST_ADD) && (cnt_q != 6'd0);
	assign hash_wdata = hash_eff + v_q[0];

	always_comb begin
		sched_we    = 1'b0;
		sched_wdata = msg.message_word;
		case (state_q)
			ST_IDLE: begin
				sched_we    = msg_valid;
				sched_wdata = msg.message_word;
			end
			ST_PAD: begin
				sched_we = 1'b1;
				if (hi_q) begin
					sched_wdata = bit_len[31:0];
				end else if (pos_q == 4'd14) begin
					sched_wdata = bit_len[63:32];
				end else begin
					sched_wdata = 32'd0;
				end
			end
			default: begin
				sched_we = 1'b0;
			end
		endcase
	end

	// the schedule word for the next round is fetched during the current round
	assign sched_raddr = (state_q == ST_ROUND) ? (cnt_q[3:0] + 4'd1) : 4'd0;

	always_comb begin
		if (cnt_q[5:4] == 2'd0) begin
			w_cur = sched_rd_s1;
		end else begin
			w_cur = sml_s1(win_q[14]) + win_q[9] + sml_s0(win_q[1]) + win_q[0];
		end
		t1 = v_q[7] + big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha256mh_pkg::ROUND_K[cnt_q] + w_cur;
		t2 = big_s0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (sched_we) begin
			sched_mem[pos_q] <= sched_wdata;
		end
		sched_rd_s1 <= sched_mem[sched_raddr];
	end

	always_ff @(posedge clk) begin
		if (hash_we) begin
			hash_mem[hash_waddr] <= hash_wdata;
		end
		hash_rd_s1    <= hash_mem[hash_raddr];
		hash_raddr_s1 <= hash_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 6'd0;
			pos_q       <= 4'd0;
			pad_q       <= 1'b0;
			hi_q        <= 1'b0;
			fin_q       <= 1'b0;
			len_q       <= '0;
			hvld_q      <= '0;
			hash_vld_s1 <= 1'b0;
			dig_valid_q <= 1'b0;
			dig_q       <= '0;
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= 32'd0;
			end
			for (int i = 0; i < 16; i++) begin
				win_q[i] <= 32'd0;
			end
		end else begin
			hash_vld_s1 <= hvld_q[hash_raddr];
			case (state_q)
				ST_IDLE: begin
					if (msg_valid) begin
						pos_q <= pos_q + 4'd1;
						if (msg.padding_end) begin
							len_q <= msg.message_bytes;
							pad_q <= 1'b1;
							hi_q  <= 1'b0;
							fin_q <= 1'b0;
						end
						if (pos_q == 4'd15) begin
							cnt_q   <= 6'd0;
							state_q <= ST_LOAD;
						end else if (msg.padding_end) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pos_q <= pos_q + 4'd1;
					if (hi_q) begin
						fin_q <= 1'b1;
					end else if (pos_q == 4'd14) begin
						hi_q <= 1'b1;
					end
					if (pos_q == 4'd15) begin
						cnt_q   <= 6'd0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					// shift hash words in from the top; after eight, a = H0
					if (cnt_q != 6'd0) begin
						for (int i = 0; i < 7; i++) begin
							v_q[i] <= v_q[i + 1];
						end
						v_q[7] <= hash_eff;
					end
					if (cnt_q == 6'd8) begin
						cnt_q   <= 6'd0;
						state_q <= ST_ROUND;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_ROUND: begin
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					for (int i = 0; i < 15; i++) begin
						win_q[i] <= win_q[i + 1];
					end
					win_q[15] <= w_cur;
					if (cnt_q == 6'd63) begin
						cnt_q   <= 6'd0;
						state_q <= ST_ADD;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_ADD: begin
					// rotate so that a lines up with the hash word being written back
					if (cnt_q != 6'd0) begin
						hvld_q[hash_waddr] <= 1'b1;
						for (int i = 0; i < 7; i++) begin
							v_q[i] <= v_q[i + 1];
						end
						v_q[7] <= v_q[0];
					end
					if (cnt_q == 6'd8) begin
						cnt_q <= 6'd0;
						if (fin_q) begin
							pad_q   <= 1'b0;
							hi_q    <= 1'b0;
							fin_q   <= 1'b0;
							state_q <= ST_ORD;
						end else if (pad_q) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_ORD: begin
					state_q <= ST_OLD;
				end
				ST_OLD: begin
					dig_q.digest_word       <= hash_eff;
					dig_q.word_index        <= cnt_q[2:0];
					dig_q.last_word         <= (cnt_q[2:0] == 3'd7);
					dig_valid_q             <= 1'b1;
					hvld_q[cnt_q[2:0]]      <= 1'b0;
					state_q                 <= ST_OWAIT;
				end
				ST_OWAIT: begin
					if (!dig_stall) begin
						dig_valid_q <= 1'b0;
						if (cnt_q[2:0] == 3'd7) begin
							cnt_q   <= 6'd0;
							state_q <= ST_IDLE;
						end else begin
							cnt_q   <= cnt_q + 6'd1;
							state_q <= ST_ORD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
